>>> hdl/lfps_pkg.sv
// Package for the line follower steering block: widths, register indexes,
// calibration tables and scaling constants. No dependencies.
package lfps_pkg;

   localparam int AdcBitsDefault = 12;
   localparam int SensorCount    = 5;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_STRAIGHT    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_SHARP       = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_DIFF    = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_ALPHA       = 3'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_LOST_LIMIT  = 3'd7;

   localparam int PctFull    = 25600;
   localparam int StepLimit  = 2458;
   localparam int IntegLimit = 1638400;

   typedef struct packed {
      logic [15:0] prop_gain;
      logic [15:0] integ_gain;
      logic [15:0] deriv_gain;
      logic [7:0]  straight_speed;
      logic [8:0]  sharp_turn_speed;
      logic [9:0]  max_wheel_diff;
      logic [15:0] smooth_alpha;
      logic [8:0]  lost_sum_limit;
   } csr_type;

   // Calibration window for 12-bit samples, scaled to the ADC width.
   function automatic int cal_lo(input int idx, input int adc_bits);
      int t;
      case (idx)
         0: t = 2250;
         1: t = 2400;
         2: t = 2600;
         3: t = 2400;
         default: t = 1400;
      endcase
      return (t * ((1 << adc_bits) - 1)) / 4095;
   endfunction

   function automatic int cal_hi(input int idx, input int adc_bits);
      int t;
      t = (idx == 1) ? 3800 : 4095;
      return (t * ((1 << adc_bits) - 1)) / 4095;
   endfunction

endpackage

>>> hdl/lfps_stream_if.sv
// Valid/ready channel carrying one item of payload type.
// Depends on nothing.
interface lfps_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hdl/lfps_divider.sv
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Depends on lfps_pkg.
module lfps_divider #(
   parameter int Width = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [Width-1:0] dividend,
   input  logic [Width-1:0] divisor,
   output logic             done,
   output logic [Width-1:0] quotient
);
   import lfps_pkg::*;
   localparam int CntWidth = $clog2(Width + 1);

   logic [Width-1:0]    quo_ff, quo_in;
   logic [Width-1:0]    rem_ff, rem_in;
   logic [Width-1:0]    dvs_ff, dvs_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [Width:0]      trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[Width-1]} - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CntWidth'(Width);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract when it fits
         if (!trial[Width]) begin
            rem_in = trial[Width-1:0];
            quo_in = {quo_ff[Width-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[Width-2:0], quo_ff[Width-1]};
            quo_in = {quo_ff[Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> hdl/lfps_multiplier.sv
// Shared shift-add multiplier, signed by unsigned, one multiplier bit per cycle.
// Depends on lfps_pkg.
module lfps_multiplier #(
   parameter int AWidth = 48,
   parameter int BWidth = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [AWidth-1:0]        mcand,
   input  logic        [BWidth-1:0]        mplier,
   output logic                            done,
   output logic signed [AWidth+BWidth-1:0] product
);
   import lfps_pkg::*;
   localparam int PWidth   = AWidth + BWidth;
   localparam int CntWidth = $clog2(BWidth + 1);

   logic signed [PWidth-1:0] acc_ff, acc_in;
   logic signed [PWidth-1:0] mc_ff, mc_in;
   logic [BWidth-1:0]        mp_ff, mp_in;
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mc_in   = PWidth'(mcand);
         mp_in   = mplier;
         cnt_in  = CntWidth'(BWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add the shifted multiplicand for each set multiplier bit
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in  = mc_ff <<< 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

>>> hdl/line_follower_pid_steering_top.sv
// Line follower steering controller: sensor scaling, weighted centroid, PID.
// A sequencer steps one shared 48-bit bit-serial divider (up to 5 reflectance divides, centroid,
// integral step, PID scaling) and one 48-by-24-bit shift-add multiplier (5 products).
// Throughput: one item at a time; next item accepted in the idle cycle after the result is taken.
// Reset: synchronous, active high; clears state and loads register defaults.
module line_follower_pid_steering_top #(
   parameter int AdcBits = lfps_pkg::AdcBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   lfps_stream_if.sink                         req,
   lfps_stream_if.source                       rsp,
   input  logic                                csr_write,
   input  logic [lfps_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [lfps_pkg::CsrDataWidth-1:0]   csr_data
);
   import lfps_pkg::*;

   localparam int DW = 48;
   localparam int MA = 48;
   localparam int MB = 24;

   // Sequencer states.
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_PCT      = 5'd1;
   localparam logic [4:0] S_PCT_W    = 5'd2;
   localparam logic [4:0] S_SUM      = 5'd3;
   localparam logic [4:0] S_POS_W    = 5'd4;
   localparam logic [4:0] S_LIMIT    = 5'd5;
   localparam logic [4:0] S_FILT1    = 5'd6;
   localparam logic [4:0] S_FILT1_W  = 5'd7;
   localparam logic [4:0] S_FILT2    = 5'd8;
   localparam logic [4:0] S_FILT2_W  = 5'd9;
   localparam logic [4:0] S_INTEG    = 5'd10;
   localparam logic [4:0] S_INTEG_W  = 5'd11;
   localparam logic [4:0] S_P_W      = 5'd12;
   localparam logic [4:0] S_I        = 5'd13;
   localparam logic [4:0] S_I_W      = 5'd14;
   localparam logic [4:0] S_D        = 5'd15;
   localparam logic [4:0] S_D_W      = 5'd16;
   localparam logic [4:0] S_BOOST_W  = 5'd17;
   localparam logic [4:0] S_SPEED    = 5'd18;
   localparam logic [4:0] S_OUT      = 5'd19;

   // Configuration registers.
   csr_type csr_ff;

   logic [4:0]               state_ff, state_in;
   logic [2:0]               idx_ff, idx_in;
   logic [SensorCount-1:0][AdcBits-1:0] samp_ff;
   logic [SensorCount-1:0][14:0]        pct_ff;
   logic signed [15:0]       spos_ff;
   logic signed [23:0]       esum_ff;
   logic signed [15:0]       lerr_ff;
   logic signed [17:0]       rawp_ff;
   logic signed [DW-1:0]     acc_ff;
   logic signed [DW-1:0]     pid_ff;
   logic                     neg_ff;
   logic signed [8:0]        left_ff, right_ff;
   logic                     halt_ff;
   logic                     rsp_valid_ff;

   logic                     div_start, div_done;
   logic [DW-1:0]            div_a, div_b, div_q;
   logic                     mul_start, mul_done;
   logic signed [MA-1:0]     mul_a;
   logic [MB-1:0]            mul_b;
   logic signed [MA+MB-1:0]  mul_p;

   lfps_divider #(.Width(DW)) u_div (
      .clock, .reset, .start(div_start), .dividend(div_a), .divisor(div_b),
      .done(div_done), .quotient(div_q)
   );

   lfps_multiplier #(.AWidth(MA), .BWidth(MB)) u_mul (
      .clock, .reset, .start(mul_start), .mcand(mul_a), .mplier(mul_b),
      .done(mul_done), .product(mul_p)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.prop_gain        <= 16'd29619;
         csr_ff.integ_gain       <= 16'd1835;
         csr_ff.deriv_gain       <= 16'd51200;
         csr_ff.straight_speed   <= 8'd50;
         csr_ff.sharp_turn_speed <= 9'd400;
         csr_ff.max_wheel_diff   <= 10'd500;
         csr_ff.smooth_alpha     <= 16'd29491;
         csr_ff.lost_sum_limit   <= 9'd15;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROP_GAIN:  csr_ff.prop_gain        <= csr_data;
            CSR_INTEG_GAIN: csr_ff.integ_gain       <= csr_data;
            CSR_DERIV_GAIN: csr_ff.deriv_gain       <= csr_data;
            CSR_STRAIGHT:   csr_ff.straight_speed   <= csr_data[7:0];
            CSR_SHARP:      csr_ff.sharp_turn_speed <= csr_data[8:0];
            CSR_MAX_DIFF:   csr_ff.max_wheel_diff   <= csr_data[9:0];
            CSR_ALPHA:      csr_ff.smooth_alpha     <= csr_data;
            CSR_LOST_LIMIT: csr_ff.lost_sum_limit   <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // Calibration for the sensor under work, from constant tables.
   logic [AdcBits-1:0] lo_sel, hi_sel, raw_sel;
   always_comb begin
      lo_sel = '0;
      hi_sel = '0;
      for (int k = 0; k < SensorCount; k++) begin
         if (idx_ff == 3'(k)) begin
            lo_sel = AdcBits'(cal_lo(k, AdcBits));
            hi_sel = AdcBits'(cal_hi(k, AdcBits));
         end
      end
      raw_sel = samp_ff[idx_ff];
   end

   // Centroid sums over the five percentages.
   logic signed [19:0] num_c;
   logic [17:0]        den_c;
   logic               white_c;
   always_comb begin
      num_c   = 20'sd0;
      den_c   = '0;
      white_c = 1'b1;
      num_c   = 20'(-2 * $signed({1'b0, pct_ff[0]}) - $signed({1'b0, pct_ff[1]})
                + $signed({1'b0, pct_ff[3]}) + 2 * $signed({1'b0, pct_ff[4]}));
      for (int k = 0; k < SensorCount; k++) begin
         den_c = den_c + 18'(pct_ff[k]);
         if (pct_ff[k] != 15'(PctFull)) white_c = 1'b0;
      end
   end

   // Shared step arithmetic.
   logic signed [18:0] delta_c;
   logic [18:0]        adelta_c;
   logic [15:0]        ae_c;
   logic signed [DW-1:0] q_signed;
   logic               sharp_c;
   logic signed [24:0] esum_clip;
   logic signed [17:0] spd_c;
   logic signed [18:0] base_c, left_c, right_c, diff_c;
   logic [8:0]         half_c;
   logic signed [DW-1:0] pid_sat;

   always_comb begin
      delta_c  = 19'(rawp_ff) - 19'(spos_ff);
      adelta_c = delta_c[18] ? 19'(-delta_c) : 19'(delta_c);
      ae_c     = spos_ff[15] ? 16'(-spos_ff) : 16'(spos_ff);
      q_signed = neg_ff ? -$signed(div_q) : $signed(div_q);
      sharp_c  = (19'(ae_c) * 19'd5) > 19'd16384;
      pid_sat  = pid_ff;
      if (pid_ff > 48'sd32767) pid_sat = 48'sd32767;
      if (pid_ff < -48'sd32768) pid_sat = -48'sd32768;
      spd_c    = 18'(pid_sat);
      base_c   = sharp_c ? 19'(csr_ff.sharp_turn_speed) : 19'(csr_ff.straight_speed);
      left_c   = base_c + 19'(spd_c);
      right_c  = base_c - 19'(spd_c);
      diff_c   = left_c - right_c;
      half_c   = csr_ff.max_wheel_diff[9:1];
      if (diff_c > $signed({9'd0, csr_ff.max_wheel_diff})) begin
         left_c  = base_c + 19'(half_c);
         right_c = base_c - 19'(half_c);
      end else if (diff_c < -$signed({9'd0, csr_ff.max_wheel_diff})) begin
         left_c  = base_c - 19'(half_c);
         right_c = base_c + 19'(half_c);
      end
      if (left_c < -19'sd20) left_c = -19'sd10;
      if (right_c < -19'sd20) right_c = -19'sd10;
      if (left_c > 19'sd255) left_c = 19'sd255;
      if (right_c > 19'sd255) right_c = 19'sd255;
      esum_clip = 25'(esum_ff);
   end

   // PID total magnitude for the final divide.
   logic signed [DW+8:0] pid_full;
   logic [DW+8:0]        pid_mag;
   always_comb begin
      pid_full = 57'(acc_ff) + 57'(mul_p);
      pid_mag  = pid_full[DW+8] ? 57'(-pid_full) : 57'(pid_full);
   end

   // Drop the low 32 bits by a shift; on a sharp turn take *11 first, the /5 follows.
   logic [DW-1:0] boost_a;
   always_comb begin
      if (sharp_c) boost_a = DW'((pid_mag * 57'd11) >> 32);
      else boost_a = DW'(pid_mag >> 32);
   end

   // Sequencer.
   logic signed [DW-1:0] tmp_num;
   logic [DW-1:0]        tmp_abs;
   logic signed [DW-1:0] inc_c, es_c;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      tmp_num   = DW'(num_c) <<< 12;
      tmp_abs   = tmp_num[DW-1] ? DW'(-tmp_num) : DW'(tmp_num);
      inc_c     = 48'(q_signed);
      es_c      = 48'(esum_clip) + inc_c;
      case (state_ff)
         S_IDLE: if (req.valid) begin
            state_in = S_PCT;
            idx_in   = '0;
         end
         S_PCT: begin
            // saturate outside the window, else divide
            if (raw_sel <= lo_sel || raw_sel >= hi_sel) begin
               state_in = (idx_ff == 3'(SensorCount - 1)) ? S_SUM : S_PCT;
               idx_in   = idx_ff + 1'b1;
            end else begin
               div_start = 1'b1;
               div_a     = DW'(raw_sel - lo_sel) * DW'(PctFull);
               div_b     = DW'(hi_sel - lo_sel);
               state_in  = S_PCT_W;
            end
         end
         S_PCT_W: if (div_done) begin
            state_in = (idx_ff == 3'(SensorCount - 1)) ? S_SUM : S_PCT;
            idx_in   = idx_ff + 1'b1;
         end
         S_SUM: begin
            if (white_c) state_in = S_OUT;
            else if (den_c < 18'({csr_ff.lost_sum_limit, 8'd0})) state_in = S_LIMIT;
            else if (den_c == '0) state_in = S_LIMIT;
            else begin
               div_start = 1'b1;
               div_a     = tmp_abs;
               div_b     = DW'(den_c);
               state_in  = S_POS_W;
            end
         end
         S_POS_W: if (div_done) state_in = S_LIMIT;
         S_LIMIT: state_in = S_FILT1;
         S_FILT1: begin
            mul_start = 1'b1;
            mul_a     = MA'(spos_ff);
            mul_b     = MB'(csr_ff.smooth_alpha);
            state_in  = S_FILT1_W;
         end
         S_FILT1_W: if (mul_done) state_in = S_FILT2;
         S_FILT2: begin
            mul_start = 1'b1;
            mul_a     = MA'(rawp_ff);
            mul_b     = MB'(17'h10000 - 17'(csr_ff.smooth_alpha));
            state_in  = S_FILT2_W;
         end
         S_FILT2_W: if (mul_done) state_in = S_INTEG;
         S_INTEG: begin
            div_start = 1'b1;
            div_a     = DW'(ae_c) * 48'd128 + 48'd500;
            div_b     = 48'd1000;
            state_in  = S_INTEG_W;
         end
         S_INTEG_W: if (div_done) begin
            mul_start = 1'b1;
            mul_a     = MA'(spos_ff) <<< 12;
            mul_b     = MB'(csr_ff.prop_gain);
            state_in  = S_P_W;
         end
         S_P_W: if (mul_done) state_in = S_I;
         S_I: begin
            mul_start = 1'b1;
            mul_a     = MA'(esum_ff);
            mul_b     = MB'(csr_ff.integ_gain);
            state_in  = S_I_W;
         end
         S_I_W: if (mul_done) state_in = S_D;
         S_D: begin
            mul_start = 1'b1;
            mul_a     = (MA'(spos_ff) - MA'(lerr_ff)) * 48'sd125 <<< 12;
            mul_b     = MB'(csr_ff.deriv_gain);
            state_in  = S_D_W;
         end
         S_D_W: if (mul_done) begin
            // divide the shifted PID magnitude by 5 on a sharp turn, else by 1
            div_start = 1'b1;
            div_a     = boost_a;
            div_b     = sharp_c ? 48'd5 : 48'd1;
            state_in  = S_BOOST_W;
         end
         S_BOOST_W: if (div_done) state_in = S_SPEED;
         S_SPEED: state_in = S_OUT;
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         for (int k = 0; k < SensorCount; k++)
            samp_ff[k] <= req.data[(SensorCount-1-k)*12 +: AdcBits];
      end
      case (state_ff)
         S_PCT: begin
            if (raw_sel <= lo_sel) pct_ff[idx_ff] <= '0;
            else if (raw_sel >= hi_sel) pct_ff[idx_ff] <= 15'(PctFull);
         end
         S_PCT_W: if (div_done) pct_ff[idx_ff] <= div_q[14:0];
         S_SUM: begin
            neg_ff <= tmp_num[DW-1];
            if (den_c < 18'({csr_ff.lost_sum_limit, 8'd0})) rawp_ff <= 18'(spos_ff);
            else rawp_ff <= '0;
         end
         S_POS_W: if (div_done) rawp_ff <= 18'(q_signed);
         S_LIMIT: if (adelta_c * 19'd5 > 19'd12288) begin
            rawp_ff <= delta_c[18] ? 18'(spos_ff) - 18'(StepLimit)
                                   : 18'(spos_ff) + 18'(StepLimit);
         end
         S_FILT1_W: if (mul_done) acc_ff <= DW'(mul_p);
         S_FILT2_W: if (mul_done) begin
            spos_ff <= 16'((acc_ff + DW'(mul_p) + 48'sd32768) >>> 16);
         end
         S_INTEG: begin
            neg_ff <= spos_ff[15];
            if (ae_c > 16'd6144) esum_ff <= '0;
         end
         S_INTEG_W: if (div_done) begin
            if (es_c > 48'(IntegLimit)) esum_ff <= 24'(IntegLimit);
            else if (es_c < -48'(IntegLimit)) esum_ff <= 24'(-IntegLimit);
            else esum_ff <= 24'(es_c);
         end
         S_P_W: if (mul_done) acc_ff <= DW'(mul_p);
         S_I_W: if (mul_done) acc_ff <= acc_ff + DW'(mul_p);
         S_D_W: if (mul_done) begin
            neg_ff <= pid_full[DW+8];
            lerr_ff <= spos_ff;
         end
         S_BOOST_W: if (div_done) pid_ff <= q_signed;
         S_SPEED: begin
            left_ff  <= 9'(left_c);
            right_ff <= 9'(right_c);
         end
         default: ;
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         spos_ff      <= '0;
         esum_ff      <= '0;
         lerr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         halt_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (state_ff == S_SUM) halt_ff <= white_c;
         if (state_in == S_OUT && state_ff != S_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_SUM && white_c) begin
            left_ff  <= '0;
            right_ff <= '0;
         end
      end
   end

   // Accept only when idle; hold the result until it is taken.
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = {left_ff, right_ff, halt_ff, spos_ff[14:0]};

   logic unused_ok;
   assign unused_ok = |mul_p[MA+MB-1:DW];

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready)) else $error("result pending while idle");

   a_idle_valid: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_IDLE && rsp_valid_ff)) else $error("valid result in idle");

   property p_hold;
      @(posedge clock) disable iff (reset) rsp.valid && !rsp.ready |=> rsp.valid;
   endproperty
   a_hold: assert property (p_hold) else $error("result dropped");

endmodule
